// ===== rtl/core/tcc_pkg.sv =====
package tcc_pkg;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_SECOND = 3'd0,
    REG_BASE_MINUTE = 3'd1,
    REG_BASE_HOUR   = 3'd2,
    REG_BASE_DAY    = 3'd3,
    REG_BASE_MONTH  = 3'd4,
    REG_BASE_YEAR   = 3'd5,
    REG_ZONE_OFFSET = 3'd6
  } reg_idx_e;

  localparam logic [5:0]  RstBaseSecond = 6'd55;
  localparam logic [5:0]  RstBaseMinute = 6'd23;
  localparam logic [4:0]  RstBaseHour   = 5'd14;
  localparam logic [4:0]  RstBaseDay    = 5'd11;
  localparam logic [3:0]  RstBaseMonth  = 4'd5;
  localparam logic [6:0]  RstBaseYear   = 7'd14;
  localparam logic [10:0] RstZoneOffset = 11'd0;

  localparam logic [31:0] DaysPerQuad = 32'd1461;

  // reciprocal multipliers for exact unsigned division
  localparam logic [31:0] RecipDiv100  = 32'h51EB851F; // >> 37
  localparam logic [31:0] RecipDiv60   = 32'h88888889; // >> 37
  localparam logic [31:0] RecipDiv24   = 32'hAAAAAAAB; // >> 36
  localparam logic [29:0] RecipDiv1461 = 30'd752574694; // >> 40, inputs below 2^22

  // cumulative days at the start of each month within a four-year block
  localparam logic [10:0] QUAD_DAYS [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  typedef struct packed {
    logic [31:0] seconds;
    logic [10:0] zone;
  } base_t;

endpackage

// ===== rtl/core/tcc_base.sv =====
module tcc_base (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcc_pkg::CfgDataW-1:0]  cfg_data_i,
  output tcc_pkg::base_t                base_o
);

  logic [5:0]  sec_q;
  logic [5:0]  min_q;
  logic [4:0]  hour_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [6:0]  year_q;
  logic [10:0] zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= tcc_pkg::RstBaseSecond;
      min_q   <= tcc_pkg::RstBaseMinute;
      hour_q  <= tcc_pkg::RstBaseHour;
      day_q   <= tcc_pkg::RstBaseDay;
      month_q <= tcc_pkg::RstBaseMonth;
      year_q  <= tcc_pkg::RstBaseYear;
      zone_q  <= tcc_pkg::RstZoneOffset;
    end else if (cfg_we_i) begin
      unique case (tcc_pkg::reg_idx_e'(cfg_idx_i))
        tcc_pkg::REG_BASE_SECOND: sec_q   <= cfg_data_i[5:0];
        tcc_pkg::REG_BASE_MINUTE: min_q   <= cfg_data_i[5:0];
        tcc_pkg::REG_BASE_HOUR:   hour_q  <= cfg_data_i[4:0];
        tcc_pkg::REG_BASE_DAY:    day_q   <= cfg_data_i[4:0];
        tcc_pkg::REG_BASE_MONTH:  month_q <= cfg_data_i[3:0];
        tcc_pkg::REG_BASE_YEAR:   year_q  <= cfg_data_i[6:0];
        tcc_pkg::REG_ZONE_OFFSET: zone_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // base date-time to seconds, two registered steps, mod 2^32
  logic [3:0]  mon_idx;
  logic [31:0] days_d, days_q;
  logic [31:0] secs_d, secs_q;

  always_comb begin
    priority if (month_q == 4'd0) begin
      mon_idx = 4'd0;
    end else if (month_q > 4'd12) begin
      mon_idx = 4'd11;
    end else begin
      mon_idx = month_q - 4'd1;
    end
    days_d  = 32'(year_q[6:2]) * tcc_pkg::DaysPerQuad
            + 32'(tcc_pkg::QUAD_DAYS[year_q[1:0]][mon_idx])
            + 32'(day_q) - 32'd1;
    secs_d  = days_q * 32'd86400 + 32'(hour_q) * 32'd3600
            + 32'(min_q) * 32'd60 + 32'(sec_q);
  end

  always_ff @(posedge clk_i) begin
    days_q  <= days_d;
    secs_q  <= secs_d;
  end

  assign base_o.seconds = secs_q;
  assign base_o.zone    = zone_q;

endmodule

// ===== rtl/core/tick_counter_to_calendar_time.sv =====
// Tick counter to calendar time.
// s_axis carries one 32-bit count of 90 ms ticks per word. m_axis returns one
// word per input word: second, minute, hour, day, month and year since 2000,
// found by adding 9 s per whole hundred ticks of the count to the configured base
// date-time and the signed zone offset to the minutes.
// The cfg port writes the base date-time and zone registers; write it only
// while no word is in flight. A write passes through days_q and secs_q in
// tcc_base before any later input word reaches the point where the base is added.
// Ten register stages, from tick_q to the *9_q output stage. Throughput: one
// word per cycle while m_axis_tready is high, set by the stage chain of
// reciprocal multipliers (at most one such product per stage).
// Each stage holds while the stage after it is full and stalled, so empty
// stages keep filling while m_axis_tready is low; s_axis_tready drops only
// when every stage holds a word.
// Reset clears all stage valid bits and loads the base registers with
// 2014-05-11 14:23:55 and zone offset zero.
module tick_counter_to_calendar_time (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // tick_count
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // second[5:0], minute[11:6], hour[16:12], day[21:17], month[25:22], year[32:26]
  output logic [39:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [tcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tcc_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned NumStages = 10;

  tcc_pkg::base_t base;

  tcc_base u_base (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .base_o     (base)
  );

  // stage control
  logic [NumStages-1:0] v_d, v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? s_axis_tvalid : v_q[0];
    for (int k = 1; k < NumStages; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // datapath
  logic [31:0] tick_q;
  logic [63:0] prod1;
  logic [25:0] q1_d, q1_q;
  logic [31:0] s2_d, s2_q;
  logic [31:0] s3_q;
  logic [63:0] prod3;
  logic [26:0] m3_d, m3_q;
  logic [31:0] m4x60;
  logic [5:0]  sec4_d, sec4_q;
  logic [31:0] t4_d, t4_q;
  logic [5:0]  sec5_q;
  logic [31:0] t5_q;
  logic [63:0] prod5;
  logic [26:0] h5_d, h5_q;
  logic [31:0] h6x60;
  logic [58:0] prod6;
  logic [5:0]  sec6_q;
  logic [5:0]  min6_d, min6_q;
  logic [26:0] h6_q;
  logic [21:0] d6_d, d6_q;
  logic [26:0] d7x24;
  logic [51:0] prod7;
  logic [5:0]  sec7_q;
  logic [5:0]  min7_q;
  logic [4:0]  hr7_d, hr7_q;
  logic [21:0] d7_q;
  logic [10:0] q47_d, q47_q;
  logic [21:0] q4x1461;
  logic [5:0]  sec8_q;
  logic [5:0]  min8_q;
  logic [4:0]  hr8_q;
  logic [10:0] rem8_d, rem8_q;
  logic [4:0]  quad8_q;
  logic [1:0]  yr9;
  logic [3:0]  mon9;
  logic [10:0] day_off9;
  logic [5:0]  sec9_q;
  logic [5:0]  min9_q;
  logic [4:0]  hr9_q;
  logic [4:0]  day9_d, day9_q;
  logic [3:0]  month9_d, month9_q;
  logic [6:0]  year9_d, year9_q;

  always_comb begin
    // whole hundreds of ticks, then 9 s each plus base
    prod1 = 64'(tick_q) * 64'(tcc_pkg::RecipDiv100);
    q1_d  = prod1[62:37];
    s2_d  = 32'(q1_q) * 32'd9 + base.seconds;
    // seconds / 60
    prod3 = 64'(s2_q) * 64'(tcc_pkg::RecipDiv60);
    m3_d  = prod3[63:37];
    m4x60 = 32'(m3_q) * 32'd60;
    sec4_d = 6'(s3_q - m4x60);
    t4_d   = 32'(m3_q) + {{21{base.zone[10]}}, base.zone};
    // minutes / 60
    prod5 = 64'(t4_q) * 64'(tcc_pkg::RecipDiv60);
    h5_d  = prod5[63:37];
    h6x60  = 32'(h5_q) * 32'd60;
    min6_d = 6'(t5_q - h6x60);
    // hours / 24
    prod6 = 59'(h5_q) * 59'(tcc_pkg::RecipDiv24);
    d6_d  = prod6[57:36];
    d7x24 = 27'(d6_q) * 27'd24;
    hr7_d = 5'(h6_q - d7x24);
    // days / 1461
    prod7 = 52'(d6_q) * 52'(tcc_pkg::RecipDiv1461);
    q47_d = prod7[50:40];
    q4x1461 = 22'(q47_q) * 22'(tcc_pkg::DaysPerQuad);
    rem8_d  = 11'(d7_q - q4x1461);
    // year and month inside the four-year block
    priority if (rem8_q >= tcc_pkg::QUAD_DAYS[3][0]) begin
      yr9 = 2'd3;
    end else if (rem8_q >= tcc_pkg::QUAD_DAYS[2][0]) begin
      yr9 = 2'd2;
    end else if (rem8_q >= tcc_pkg::QUAD_DAYS[1][0]) begin
      yr9 = 2'd1;
    end else begin
      yr9 = 2'd0;
    end
    mon9 = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (rem8_q >= tcc_pkg::QUAD_DAYS[yr9][m]) begin
        mon9 = 4'(m);
      end
    end
    day_off9 = rem8_q - tcc_pkg::QUAD_DAYS[yr9][mon9];
    day9_d   = 5'(day_off9 + 11'd1);
    month9_d = mon9 + 4'd1;
    year9_d  = {quad8_q, yr9};
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tick_q <= s_axis_tdata;
    end
    if (en[1]) begin
      q1_q <= q1_d;
    end
    if (en[2]) begin
      s2_q <= s2_d;
    end
    if (en[3]) begin
      s3_q <= s2_q;
      m3_q <= m3_d;
    end
    if (en[4]) begin
      sec4_q <= sec4_d;
      t4_q   <= t4_d;
    end
    if (en[5]) begin
      sec5_q <= sec4_q;
      t5_q   <= t4_q;
      h5_q   <= h5_d;
    end
    if (en[6]) begin
      sec6_q <= sec5_q;
      min6_q <= min6_d;
      h6_q   <= h5_q;
      d6_q   <= d6_d;
    end
    if (en[7]) begin
      sec7_q <= sec6_q;
      min7_q <= min6_q;
      hr7_q  <= hr7_d;
      d7_q   <= d6_q;
      q47_q  <= q47_d;
    end
    if (en[8]) begin
      sec8_q  <= sec7_q;
      min8_q  <= min7_q;
      hr8_q   <= hr7_q;
      rem8_q  <= rem8_d;
      quad8_q <= q47_q[4:0];
    end
    if (en[9]) begin
      sec9_q   <= sec8_q;
      min9_q   <= min8_q;
      hr9_q    <= hr8_q;
      day9_q   <= day9_d;
      month9_q <= month9_d;
      year9_q  <= year9_d;
    end
  end

  // stage names above: tick_q is stage 0, *9_q is the output stage
  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NumStages-1];
  assign m_axis_tdata  = {7'd0, year9_q, month9_q, day9_q, hr9_q, min9_q, sec9_q};

`ifndef NO_ASSERTIONS
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage is empty");

  a_out_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (sec9_q < 6'd60) && (min9_q < 6'd60) && (hr9_q < 5'd24)
                      && (month9_q >= 4'd1) && (month9_q <= 4'd12) && (day9_q != 5'd0))
    else $error("calendar field out of range");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[5] && !en[5]) |=> v_q[5])
    else $error("stalled word lost in pipeline");

  a_no_stall_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready || !m_axis_tvalid) |-> (en == {NumStages{1'b1}}))
    else $error("stage held while output is free");
`endif

endmodule
